// ----- design/adaptive_ternary_range_decoder_assert.svh -----
`ifndef ADAPTIVE_TERNARY_RANGE_DECODER_ASSERT_SVH
`define ADAPTIVE_TERNARY_RANGE_DECODER_ASSERT_SVH
// assertion macros
`ifndef ASSERT_OFF
`define ATRD_ASSERT_IMP(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");
`define ATRD_ASSERT_NXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define ATRD_ASSERT_IMP(label, clk, rst, a, b)
`define ATRD_ASSERT_NXT(label, clk, rst, a, b)
`endif
`endif

// ----- design/atrd_pkg.sv -----
`default_nettype none
package atrd_pkg;
  localparam int FirstDepth = 512;
  localparam int SecondDepth = 4096;
  localparam int FirstAw = $clog2(FirstDepth);
  localparam int SecondAw = $clog2(SecondDepth);
  localparam logic [12:0] FreqMax = 13'd8191;

  typedef enum logic [1:0] {
    MODE_RESET = 2'd0, MODE_INIT = 2'd1, MODE_PUSH = 2'd2, MODE_DECODE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ERR_OK = 2'd0, ERR_BYTE = 2'd1, ERR_EARLY = 2'd2
  } err_t;

  localparam logic CFG_FIRST = 1'b0;
  localparam logic CFG_SECOND = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE, S_CLEAR, S_DEC0, S_DEC1, S_DEC2, S_DEC3, S_NORM, S_HRD, S_HWAIT,
    S_UPD, S_RS0, S_RS1, S_DIV, S_RS2, S_RS3, S_RS4, S_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [14:0] total;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;
endpackage
`default_nettype wire

// ----- design/atrd_div.sv -----
`default_nettype none
module atrd_div
  import atrd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);
  logic [5:0]  cnt;
  logic [15:0] rem;
  logic [14:0] den;
  logic [31:0] quot;
  logic [15:0] trial;
  logic        num_bit;

  always_comb begin
    num_bit = (cnt == 6'd32);
    trial = {rem[14:0], num_bit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      rsp.busy <= 1'b0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        cnt <= 6'd32;
        rem <= '0;
        den <= req.total;
        quot <= '0;
        rsp.busy <= (req.total != '0);
        rsp.done <= (req.total == '0);
      end else if (rsp.busy) begin
        if (trial >= {1'b0, den}) begin
          rem <= trial - {1'b0, den};
          quot <= {quot[30:0], 1'b1};
        end else begin
          rem <= trial;
          quot <= {quot[30:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          rsp.busy <= 1'b0;
          rsp.done <= 1'b1;
        end
      end
    end
  end
  assign rsp.quot = quot;
endmodule
`default_nettype wire

// ----- design/atrd_hist.sv -----
`default_nettype none
module atrd_hist
  import atrd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                sel,
  input  wire logic                we,
  input  wire logic [SecondAw-1:0] addr,
  input  wire logic [1:0]          wdata,
  output logic [1:0]               rdata
);
  logic [1:0] mem0 [FirstDepth];
  logic [1:0] mem1 [SecondDepth];
  logic [1:0] rd0, rd1;
  logic       sel_q;

  always_ff @(posedge clk) begin
    if (we && !sel) mem0[addr[FirstAw-1:0]] <= wdata;
    if (we && sel) mem1[addr] <= wdata;
    rd0 <= mem0[addr[FirstAw-1:0]];
    rd1 <= mem1[addr];
    sel_q <= sel;
  end
  assign rdata = sel_q ? rd1 : rd0;
endmodule
`default_nettype wire

// ----- design/adaptive_ternary_range_decoder.sv -----
// Adaptive ternary range decoder.
// Input channel (valid/ready): mode, stream_select, byte_in; one result
// word per input word on the output channel (valid/ready): symbol,
// bytes_needed, range_now, error. Config channel (cfg_valid/cfg_ready)
// writes the window registers, index 0 first_window, 1 second_window.
// One word is processed at a time. A decode searches for the symbol,
// renormalizes the range one byte at a time, updates the window history
// and, once a frequency reaches its threshold, rescales through the
// bit-serial 2^31/total divider (32 steps). Init clears the window in the
// history memory, one entry a cycle (up to 4096), then rescales.
// A new word can be taken in the cycle after the result is read.
// Models keep their frequency, threshold and cumulative tables in
// registers; window history sits in single-port synchronous RAM,
// read-modify-write under the sequencer.
// Reset (rst, synchronous) returns range to all ones, code and counts to
// zero, windows to 256. The result stays in the output register while
// the receiver stalls; no new word is taken until it is read.
// Decode with bytes pending or a push with none pending reports an error
// and changes nothing.
`default_nettype none
module adaptive_ternary_range_decoder
  import atrd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        valid,
  output logic             ready,
  input  wire logic [1:0]  mode,
  input  wire logic        stream_select,
  input  wire logic [7:0]  byte_in,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [12:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       symbol,
  output logic [2:0]       bytes_needed,
  output logic [31:0]      range_now,
  output logic [1:0]       error
);
  `include "adaptive_ternary_range_decoder_assert.svh"

  state_t state, state_next;
  logic [9:0]  first_window;
  logic [12:0] second_window;
  logic [31:0] coder_range, coder_code;
  logic [2:0]  bytes_pending;
  logic [12:0] freq [2][3];
  logic [12:0] thresh [2][3];
  logic [15:0] cum [2][3];
  logic [12:0] pos [2];
  logic [12:0] fill [2];
  logic [12:0] win [2];
  logic        s;
  logic [1:0]  sym, old;
  logic [16:0] rr;
  logic [31:0] prod;
  logic [2:0]  k;
  logic [12:0] clr;
  logic [14:0] run1, run2, run3;
  logic [31:0] scale;
  logic [46:0] mprod;
  logic [1:0]  ri;
  logic        hwe;
  logic [SecondAw-1:0] haddr;
  logic [1:0]  hwdata, hrdata;
  div_req_t dreq;
  div_rsp_t drsp;
  logic [12:0] wsel, wclamp, cap;
  logic [15:0] cumsym, cumnext;
  logic [12:0] fb, fnew;
  logic        full;

  atrd_div u_div (.clk, .rst, .req(dreq), .rsp(drsp));
  atrd_hist u_hist (.clk, .sel(s), .we(hwe), .addr(haddr), .wdata(hwdata),
                    .rdata(hrdata));

  assign ready = (state == S_IDLE) && !out_valid;
  assign cfg_ready = 1'b1;
  assign bytes_needed = bytes_pending;
  assign range_now = coder_range;

  always_comb begin
    cap = s ? 13'(SecondDepth) : 13'(FirstDepth);
    wsel = s ? second_window : {3'd0, first_window};
    wclamp = (wsel == '0) ? 13'd256 : wsel;
    if (wclamp > cap) wclamp = cap;
    cumsym = (sym == 2'd0) ? 16'd0 : cum[s][sym - 2'd1];
    cumnext = cum[s][sym];
    full = !(fill[s] < win[s]);
    fb = freq[s][sym];
    if (fb < FreqMax) fb = fb + 13'd1;
    fnew = (full && old == sym && freq[s][sym] >= 13'd2) ? freq[s][sym] : fb;
    run1 = {2'd0, freq[s][0]};
    run2 = run1 + {2'd0, freq[s][1]};
    run3 = run2 + {2'd0, freq[s][2]};
    dreq.start = (state == S_RS1);
    dreq.total = run3;
    hwe = 1'b0;
    haddr = '0;
    hwdata = sym;
    if (state == S_CLEAR) begin
      hwe = 1'b1;
      haddr = SecondAw'(clr);
      hwdata = 2'd0;
    end else if (state == S_NORM || state == S_HRD) begin
      haddr = SecondAw'(pos[s]);
    end else if (state == S_UPD) begin
      hwe = 1'b1;
      haddr = full ? SecondAw'(pos[s]) : SecondAw'(fill[s]);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (valid && ready) begin
        priority case (mode_t'(mode))
          MODE_INIT: state_next = S_CLEAR;
          MODE_DECODE: state_next = (bytes_pending != 0) ? S_OUT : S_DEC0;
          default: state_next = S_OUT;
        endcase
      end
      S_CLEAR: if (clr + 13'd1 >= wclamp) state_next = S_RS0;
      S_DEC0: state_next = S_DEC1;
      S_DEC1: state_next = S_DEC2;
      S_DEC2: state_next = S_DEC3;
      S_DEC3: state_next = S_NORM;
      S_NORM: if (coder_range[31:24] != 0 || k == 3'd4) state_next = S_HRD;
      S_HRD: state_next = S_HWAIT;
      S_HWAIT: state_next = S_UPD;
      S_UPD: state_next = (fnew >= thresh[s][sym]) ? S_RS0 : S_OUT;
      S_RS0: state_next = S_RS1;
      S_RS1: state_next = S_DIV;
      S_DIV: if (drsp.done) state_next = S_RS2;
      S_RS2: state_next = S_RS3;
      S_RS3: state_next = S_RS4;
      S_RS4: state_next = (ri == 2'd2) ? S_OUT : S_RS3;
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      first_window <= 10'd256;
      second_window <= 13'd256;
      coder_range <= '1;
      coder_code <= '0;
      bytes_pending <= '0;
      for (int m = 0; m < 2; m++) begin
        for (int j = 0; j < 3; j++) begin
          freq[m][j] <= '0;
          thresh[m][j] <= '0;
          cum[m][j] <= '0;
        end
        pos[m] <= '0;
        fill[m] <= '0;
        win[m] <= '0;
      end
      s <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_FIRST) first_window <= cfg_data[9:0];
        else second_window <= cfg_data;
      end
      unique case (state)
        S_IDLE: if (valid && ready) begin
          s <= stream_select;
          symbol <= '0;
          error <= ERR_OK;
          clr <= '0;
          k <= '0;
          unique case (mode_t'(mode))
            MODE_RESET: begin
              coder_range <= '1;
              coder_code <= '0;
              bytes_pending <= 3'd4;
            end
            MODE_INIT: ;
            MODE_PUSH: begin
              if (bytes_pending == 0) error <= ERR_BYTE;
              else begin
                coder_code <= {coder_code[23:0], byte_in};
                bytes_pending <= bytes_pending - 3'd1;
              end
            end
            MODE_DECODE: if (bytes_pending != 0) error <= ERR_EARLY;
            default: ;
          endcase
        end
        S_CLEAR: begin
          if (clr == '0) begin
            win[s] <= wclamp;
            pos[s] <= '0;
            fill[s] <= '0;
            freq[s][0] <= s ? 13'd90 : 13'd54;
            freq[s][1] <= s ? 13'd16 : 13'd12;
            freq[s][2] <= 13'd1;
          end
          clr <= clr + 13'd1;
        end
        S_DEC0: begin
          rr <= coder_range[31:15];
          prod <= coder_range[31:15] * cum[s][0];
        end
        S_DEC1: begin
          sym <= (prod <= coder_code) ? 2'd1 : 2'd0;
          prod <= rr * cum[s][1];
        end
        S_DEC2: begin
          if (sym == 2'd1 && prod <= coder_code) sym <= 2'd2;
        end
        S_DEC3: begin
          coder_code <= coder_code - 32'(rr) * {16'd0, cumsym};
          coder_range <= 32'(rr) * {16'd0, cumnext - cumsym};
        end
        S_NORM: begin
          if (coder_range[31:24] == 0 && k != 3'd4) begin
            coder_range <= {coder_range[23:0], 8'd0};
            k <= k + 3'd1;
          end else bytes_pending <= k;
        end
        S_HWAIT: old <= hrdata;
        S_UPD: begin
          symbol <= sym;
          if (!full) fill[s] <= fill[s] + 13'd1;
          else pos[s] <= (pos[s] + 13'd1 >= win[s]) ? '0 : pos[s] + 13'd1;
          for (int j = 0; j < 3; j++) begin
            if (2'(j) == sym) freq[s][j] <= fnew;
            else if (full && 2'(j) == old && freq[s][j] >= 13'd2)
              freq[s][j] <= freq[s][j] - 13'd1;
          end
        end
        S_RS0: begin
          for (int j = 0; j < 3; j++) begin
            if ({1'b0, freq[s][j]} + {6'd0, freq[s][j][12:5]} > {1'b0, FreqMax})
              thresh[s][j] <= FreqMax;
            else thresh[s][j] <= freq[s][j] + {5'd0, freq[s][j][12:5]};
          end
        end
        S_RS2: begin
          scale <= drsp.quot;
          ri <= '0;
        end
        S_RS3: begin
          unique case (ri)
            2'd0: mprod <= 47'(run1 * scale);
            2'd1: mprod <= 47'(run2 * scale);
            default: mprod <= 47'(run3 * scale);
          endcase
        end
        S_RS4: begin
          cum[s][ri] <= mprod[31:16];
          ri <= ri + 2'd1;
        end
        S_OUT: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

  `ATRD_ASSERT_IMP(a_pend_max, clk, rst, 1'b1, bytes_pending <= 3'd4)
  `ATRD_ASSERT_IMP(a_no_take, clk, rst, out_valid, !ready)
  `ATRD_ASSERT_NXT(a_out_idle, clk, rst, state == S_OUT, out_valid && state == S_IDLE)
endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
`default_nettype none
module testbench
  import atrd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FREQ_SAT = 8191;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [1:0]  sym;
    logic [2:0]  need;
    logic [31:0] rng;
    err_t        err;
  } decode_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        valid = 1'b0;
  logic        ready;
  logic [1:0]  mode = MODE_RESET;
  logic        stream_select = 1'b0;
  logic [7:0]  byte_in = 8'd0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_FIRST;
  logic [12:0] cfg_data = 13'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  symbol;
  logic [2:0]  bytes_needed;
  logic [31:0] range_now;
  logic [1:0]  error;

  adaptive_ternary_range_decoder dut (
    .clk(clk), .rst(rst), .valid(valid), .ready(ready), .mode(mode),
    .stream_select(stream_select), .byte_in(byte_in), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready), .symbol(symbol),
    .bytes_needed(bytes_needed), .range_now(range_now), .error(error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // decoder shadow state
  logic [31:0] win_reg [2];
  logic [31:0] coder_rng, coder_val;
  int unsigned pend;
  int unsigned freq [2][3];
  int unsigned thr [2][3];
  int unsigned cum [2][4];
  int unsigned wpos [2];
  int unsigned wfill [2];
  int unsigned wlen [2];
  logic [1:0]  hist_a [FirstDepth];
  logic [1:0]  hist_b [SecondDepth];

  decode_result_t expected_q [$];
  int fail_count = 0;
  int cycles = 0;
  bit steady = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int unsigned hist_depth(bit s);
    return s ? SecondDepth : FirstDepth;
  endfunction

  function automatic void rescale_model(bit s);
    int unsigned run [4];
    int unsigned t, total, scale;
    longint unsigned prod;
    run[0] = 0;
    for (int i = 0; i < 3; i++) begin
      t = freq[s][i] + (freq[s][i] >> 5);
      run[i+1] = run[i] + freq[s][i];
      thr[s][i] = (t > FREQ_SAT) ? FREQ_SAT : t;
    end
    total = run[3];
    scale = total ? 32'h8000_0000 / total : 0;
    cum[s][0] = 0;
    for (int i = 1; i <= 3; i++) begin
      prod = longint'(run[i]) * longint'(scale);
      cum[s][i] = int'(prod >> 16);
    end
  endfunction

  function automatic void bump_freq(bit s, int sym);
    if (freq[s][sym] < FREQ_SAT) freq[s][sym]++;
    if (freq[s][sym] >= thr[s][sym]) rescale_model(s);
  endfunction

  function automatic void store_hist(bit s, int unsigned i, logic [1:0] v);
    if (i >= hist_depth(s)) return;
    if (s) hist_b[i] = v;
    else hist_a[i] = v;
  endfunction

  function automatic void update_model(bit s, int sym);
    int unsigned old;
    if (wfill[s] < wlen[s]) begin
      bump_freq(s, sym);
      store_hist(s, wfill[s], sym[1:0]);
      wfill[s]++;
    end else begin
      old = 0;
      if (wpos[s] < hist_depth(s)) old = s ? hist_b[wpos[s]] : hist_a[wpos[s]];
      if (old < 3 && freq[s][old] >= 2) freq[s][old]--;
      bump_freq(s, sym);
      store_hist(s, wpos[s], sym[1:0]);
      wpos[s]++;
      if (wpos[s] >= wlen[s]) wpos[s] = 0;
    end
  endfunction

  function automatic void init_model(bit s);
    int unsigned w;
    w = win_reg[s];
    if (w == 0) w = 256;
    if (w > hist_depth(s)) w = hist_depth(s);
    if (w < 1) w = 1;
    wlen[s] = w;
    wpos[s] = 0;
    wfill[s] = 0;
    for (int unsigned i = 0; i < w; i++) store_hist(s, i, 2'd0);
    freq[s][0] = s ? 90 : 54;
    freq[s][1] = s ? 16 : 12;
    freq[s][2] = 1;
    rescale_model(s);
  endfunction

  function automatic decode_result_t predict_word(mode_t m, bit s, logic [7:0] b);
    decode_result_t res;
    logic [31:0] r, lo, hi;
    int sym, k;
    res.sym = 2'd0;
    res.err = ERR_OK;
    case (m)
      MODE_RESET: begin
        coder_rng = 32'hFFFF_FFFF;
        coder_val = 32'd0;
        pend = 4;
      end
      MODE_INIT: init_model(s);
      MODE_PUSH: begin
        if (pend == 0) res.err = ERR_BYTE;
        else begin
          coder_val = {coder_val[23:0], b};
          pend--;
        end
      end
      default: begin
        if (pend != 0) res.err = ERR_EARLY;
        else begin
          r = coder_rng >> 15;
          sym = 0;
          lo = r * 32'(cum[s][1]);
          if (lo <= coder_val) begin
            sym = 1;
            hi = r * 32'(cum[s][2]);
            if (hi <= coder_val) sym = 2;
          end
          coder_val = coder_val - r * 32'(cum[s][sym]);
          coder_rng = r * 32'(cum[s][sym+1] - cum[s][sym]);
          k = 0;
          while (coder_rng[31:24] == 8'd0 && k < 4) begin
            coder_rng = coder_rng << 8;
            k++;
          end
          pend = k;
          update_model(s, sym);
          res.sym = sym[1:0];
        end
      end
    endcase
    res.need = pend[2:0];
    res.rng = coder_rng;
    return res;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    fail_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report("unexpected word", range_now, 32'd0);
      end else begin
        decode_result_t e;
        e = expected_q.pop_front();
        if (symbol !== e.sym) report("symbol", 32'(symbol), 32'(e.sym));
        if (bytes_needed !== e.need)
          report("bytes_needed", 32'(bytes_needed), 32'(e.need));
        if (range_now !== e.rng) report("range_now", range_now, e.rng);
        if (error !== e.err) report("error", 32'(error), 32'(e.err));
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int n;
    @(negedge clk);
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
    end
  end

  task automatic send_word(mode_t m, bit s, logic [7:0] b);
    int n;
    n = pick_gap();
    @(negedge clk);
    if (n > 0) begin
      valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    valid <= 1'b1;
    mode <= m;
    stream_select <= s;
    byte_in <= b;
    @(posedge clk);
    while (!ready) @(posedge clk);
    expected_q.push_back(predict_word(m, s, b));
  endtask

  task automatic drain();
    @(negedge clk);
    valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [12:0] data);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    win_reg[idx] = (idx == CFG_FIRST) ? {22'd0, data[9:0]} : {19'd0, data};
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  // well-formed decode traffic with some broken commands mixed in
  task automatic run_session(int count, int noise);
    int r;
    bit s;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      s = 1'($urandom_range(0, 1));
      if (r < noise) begin
        case ($urandom_range(0, 3))
          0: send_word(MODE_PUSH, s, pick_byte());
          1: send_word(MODE_DECODE, s, pick_byte());
          2: send_word(MODE_RESET, s, pick_byte());
          default: send_word(MODE_INIT, s, pick_byte());
        endcase
      end else if (pend != 0) begin
        send_word(MODE_PUSH, s, pick_byte());
      end else begin
        send_word(MODE_DECODE, s, pick_byte());
      end
    end
  endtask

  task automatic test_directed();
    send_word(MODE_INIT, 1'b0, 8'h00);
    send_word(MODE_INIT, 1'b1, 8'hFF);
    send_word(MODE_DECODE, 1'b0, 8'h00);
    send_word(MODE_PUSH, 1'b0, 8'hA5);
    send_word(MODE_RESET, 1'b1, 8'h5A);
    send_word(MODE_DECODE, 1'b0, 8'h00);
    send_word(MODE_PUSH, 1'b0, 8'hFF);
    send_word(MODE_PUSH, 1'b1, 8'hFF);
    send_word(MODE_PUSH, 1'b0, 8'h00);
    send_word(MODE_PUSH, 1'b1, 8'h00);
    send_word(MODE_DECODE, 1'b0, 8'h00);
    while (pend != 0) send_word(MODE_PUSH, 1'b0, 8'h00);
    send_word(MODE_DECODE, 1'b1, 8'hFF);
    send_word(MODE_RESET, 1'b0, 8'h00);
    repeat (4) send_word(MODE_PUSH, 1'b1, 8'h80);
    send_word(MODE_DECODE, 1'b1, 8'h00);
    while (pend != 0) send_word(MODE_PUSH, 1'b0, 8'h7F);
    send_word(MODE_DECODE, 1'b0, 8'h00);
  endtask

  task automatic test_windows();
    logic [12:0] first_set [5];
    logic [12:0] second_set [5];
    first_set = '{13'd1, 13'd512, 13'd0, 13'd1023, 13'd3};
    second_set = '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd2};
    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_FIRST, first_set[p]);
      write_reg(CFG_SECOND, second_set[p]);
      steady = (p == 2);
      send_word(MODE_INIT, 1'b0, 8'h00);
      send_word(MODE_INIT, 1'b1, 8'h00);
      send_word(MODE_RESET, 1'b0, 8'h00);
      run_session(60, 4);
    end
    steady = 1'b0;
  endtask

  task automatic test_random();
    for (int p = 0; p < 10; p++) begin
      write_reg(CFG_FIRST, 13'($urandom_range(0, 8191)));
      write_reg(CFG_SECOND, 13'($urandom_range(0, 300)));
      send_word(MODE_INIT, 1'b0, pick_byte());
      send_word(MODE_INIT, 1'b1, pick_byte());
      steady = (p % 4 == 3);
      run_session(100, 6);
    end
    steady = 1'b0;
  endtask

  initial begin
    win_reg[0] = 256;
    win_reg[1] = 256;
    coder_rng = 32'hFFFF_FFFF;
    coder_val = 32'd0;
    pend = 0;
    for (int s = 0; s < 2; s++) begin
      wpos[s] = 0;
      wfill[s] = 0;
      wlen[s] = 0;
      for (int i = 0; i < 3; i++) begin
        freq[s][i] = 0;
        thr[s][i] = 0;
      end
      for (int i = 0; i < 4; i++) cum[s][i] = 0;
    end
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_windows();
    test_random();
    drain();
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule
`default_nettype wire
